// ===== rtl/sm4_cbc_encrypt_top_macros.svh =====
// Assertion macros for the SM4 CBC encryption block.
`ifndef SM4_CBC_ENCRYPT_TOP_MACROS_SVH
`define SM4_CBC_ENCRYPT_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define SM4_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define SM4_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("reset check failed");
`else
`define SM4_ASSERT(label, clk, rstn, prop)
`define SM4_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== rtl/sm4_pkg.sv =====
package sm4_pkg;

  localparam int RoundCount = 32;
  localparam int RndW = $clog2(RoundCount);

  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [1:0] CFG_IV_HIGH  = 2'd2;
  localparam logic [1:0] CFG_IV_LOW   = 2'd3;

  localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_CRYPT,
    ST_OUT
  } state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // CK word i: byte j is (4i+j)*7 modulo 256.
  function automatic logic [31:0] ck_word(logic [RndW-1:0] i);
    logic [7:0] b0;
    b0 = 8'({i, 2'b00}) * 8'd7;
    return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
  endfunction

endpackage

// ===== rtl/sm4_cbc_encrypt_top.sv =====
// SM4 block encryption in CBC mode.
// Input channel: plain_high_i/plain_low_i/restart_i, accepted when in_valid_i and
// in_ready_o are both high. Output channel: cipher_high_o/cipher_low_o, a
// transaction completes when out_valid_o and out_ready_i are both high.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 key high,
// 1 key low, 2 IV high, 3 IV low). The user must make writes only while the
// block is idle; the block itself does not enforce this.
// Datapath: one round per cycle, round keys read from a 32-entry
// synchronous memory. A block runs all 32 rounds and then presents the
// result in the output state. The first block after a key write (or reset)
// first expands the round keys into the memory. The CBC chain makes each
// block depend on the previous ciphertext, so one block is in flight at a time.
// Reset clears the chaining value, the key/IV registers and marks the round
// keys as stale. If the receiver stalls, the result register holds and no new
// transaction is accepted until the ciphertext is taken.
module sm4_cbc_encrypt_top import sm4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o
);

`include "sm4_cbc_encrypt_top_macros.svh"

  logic [127:0] key_q, iv_q, chain_q;
  logic         keys_ready_q;
  state_e       state_q, state_d;
  logic [RndW:0] cnt_q, cnt_d;
  logic [31:0]  x_q [4];
  logic [31:0]  x_d [4];
  logic [31:0]  rk_mem [RoundCount];
  logic [31:0]  rk_rd_q;
  logic         rk_we;
  logic [RndW-1:0] rk_waddr, rk_raddr;
  logic [31:0]  rk_wdata;
  logic [31:0]  mix, b, nw;
  logic [127:0] start_blk;
  logic         accept;
  logic [127:0] pend_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign accept      = in_valid_i && in_ready_o;
  assign cipher_high_o = chain_q[127:64];
  assign cipher_low_o  = chain_q[63:0];
  assign start_blk = {plain_high_i, plain_low_i} ^ (restart_i ? iv_q : chain_q);

  // Round key memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_mem[rk_waddr] <= rk_wdata;
    end
    rk_rd_q <= rk_mem[rk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      iv_q <= '0;
      chain_q <= '0;
      keys_ready_q <= 1'b0;
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY_HIGH: begin
            key_q[127:64] <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          CFG_KEY_LOW: begin
            key_q[63:0] <= cfg_data_i;
            keys_ready_q <= 1'b0;
          end
          CFG_IV_HIGH: iv_q[127:64] <= cfg_data_i;
          CFG_IV_LOW:  iv_q[63:0] <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_EXPAND && state_d != ST_EXPAND) begin
        keys_ready_q <= 1'b1;
      end
      if (state_q == ST_CRYPT && state_d == ST_OUT) begin
        chain_q <= {x_d[3], x_d[2], x_d[1], x_d[0]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // Shared round datapath: key schedule uses CK and L', encryption the
  // round key from memory and L.
  always_comb begin
    mix = x_q[1] ^ x_q[2] ^ x_q[3] ^
          ((state_q == ST_EXPAND) ? ck_word(cnt_q[RndW-1:0]) : rk_rd_q);
    b = tau(mix);
    if (state_q == ST_EXPAND) begin
      nw = x_q[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
    end else begin
      nw = x_q[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    x_d = x_q;
    rk_we = 1'b0;
    rk_waddr = cnt_q[RndW-1:0];
    rk_wdata = nw;
    rk_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (keys_ready_q) begin
            state_d = ST_CRYPT;
            x_d = '{start_blk[127:96], start_blk[95:64], start_blk[63:32], start_blk[31:0]};
          end else begin
            state_d = ST_EXPAND;
            // The chained block waits in pend_q while the keys expand.
            x_d = '{key_q[127:96] ^ FK[127:96], key_q[95:64] ^ FK[95:64],
                    key_q[63:32] ^ FK[63:32], key_q[31:0] ^ FK[31:0]};
          end
          cnt_d = '0;
        end
      end
      ST_EXPAND: begin
        rk_we = 1'b1;
        x_d = '{x_q[1], x_q[2], x_q[3], nw};
        cnt_d = cnt_q + 1'b1;
        rk_raddr = '0;
        if (cnt_q == (RndW+1)'(RoundCount - 1)) begin
          state_d = ST_CRYPT;
          cnt_d = '0;
          x_d = '{pend_q[127:96], pend_q[95:64], pend_q[63:32], pend_q[31:0]};
        end
      end
      ST_CRYPT: begin
        rk_raddr = cnt_q[RndW-1:0] + 1'b1;
        x_d = '{x_q[1], x_q[2], x_q[3], nw};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (RndW+1)'(RoundCount - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Chained input block kept while the key schedule runs. The IDLE read of
  // address zero primes the memory for the first round.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= start_blk;
    end
  end

  `SM4_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> !in_ready_o)
  `SM4_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(chain_q)))
  `SM4_ASSERT(a_keys_before_crypt, clk_i, rst_ni, (state_q == ST_CRYPT) |-> keys_ready_q)
  `SM4_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |=> (state_q == ST_IDLE))

endmodule
